/* hw/rtl/pad_pkg.sv */
// pad_pkg: shared types, constants and config register codes for pot_average_deadband.
// Used by every module in hw/rtl. Has no dependencies of its own.
package pad_pkg;

    // Field widths, fixed by the data formats
    localparam int SAMPLE_W = 10;
    localparam int Q6_W     = 16;   // Q10.6 values and 16-bit registers
    localparam int FRAC_W   = 6;
    localparam int GAIN_SH  = 12;   // Q4.12 gain
    localparam int PROD_W   = 32;   // diff * gain

    // Group size; valid range 1..64
    localparam int SAMPLES_PER_READING = 8;
    localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_READING - 1);

    // Mean by reciprocal multiply: exact for any 16-bit sum and a group of up to 64
    localparam int RECIP_K = 22;
    localparam int RECIP_W = RECIP_K + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_K) + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING);
    localparam int MEAN_PROD_W = Q6_W + RECIP_W;

    // Clamp limits, Q10.6
    localparam int LEVEL_W = PROD_W - GAIN_SH;
    localparam logic [LEVEL_W-1:0] LEVEL_FLOOR_Q6 = LEVEL_W'(128);    // 2.0
    localparam logic [LEVEL_W-1:0] LEVEL_TOP_Q6   = LEVEL_W'(65280);  // 1020.0
    localparam logic [Q6_W-1:0]    LEVEL_MAX_Q6   = Q6_W'(65472);     // 1023.0

    // Config port
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET   = 2'd0,
        CFG_GAIN     = 2'd1,
        CFG_DEADBAND = 2'd2
    } t_cfg_idx;

    localparam logic [Q6_W-1:0] OFFSET_RST   = Q6_W'(0);
    localparam logic [Q6_W-1:0] GAIN_RST     = Q6_W'(4096);
    localparam logic [Q6_W-1:0] DEADBAND_RST = Q6_W'(128);

    // Item passed from the gain stage to the hold stage
    typedef struct packed {
        logic              pos;   // mean above offset
        logic [PROD_W-1:0] prod;  // (mean - offset) * gain
    } t_gain_item;

endpackage

/* hw/rtl/pad_accum.sv */
// pad_accum: sums raw samples in groups and hands each finished group sum downstream.
// Depends on pad_pkg.
module pad_accum
    import pad_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_stall,
    output logic                o_grp_valid,
    output logic [Q6_W-1:0]     o_grp_sum,
    input  logic                i_grp_ready
);

    logic [Q6_W-1:0]  r_sum, n_sum;
    logic [CNT_W-1:0] r_cnt;
    logic             r_grp_vld;
    logic [Q6_W-1:0]  r_grp_sum;
    logic             slot_ready, accept, last;

    // Group slot frees when empty or being taken
    assign slot_ready = !r_grp_vld || i_grp_ready;
    assign o_stall    = !slot_ready;
    assign accept     = i_valid && slot_ready;
    assign last       = (r_cnt == CNT_LAST);
    assign n_sum      = r_sum + Q6_W'(i_sample);   // wraps at 16 bits

    // Running sum and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (accept) begin
            if (last) begin
                r_sum <= '0;
                r_cnt <= '0;
            end else begin
                r_sum <= n_sum;
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // Finished group register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_vld <= 1'b0;
        end else if (accept && last) begin
            r_grp_vld <= 1'b1;
        end else if (i_grp_ready) begin
            r_grp_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && last) begin
            r_grp_sum <= n_sum;
        end
    end

    assign o_grp_valid = r_grp_vld;
    assign o_grp_sum   = r_grp_sum;

endmodule

/* hw/rtl/pad_cond.sv */
// pad_cond: group mean by reciprocal multiply, then offset subtract and gain multiply.
// Two registered stages. Depends on pad_pkg.
module pad_cond
    import pad_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [Q6_W-1:0] i_sum,
    output logic            o_ready,
    input  logic [Q6_W-1:0] i_offset_q6,
    input  logic [Q6_W-1:0] i_gain_q12,
    output logic            o_valid,
    output t_gain_item      o_item,
    input  logic            i_ready
);

    logic                   r_m_vld, r_g_vld;
    logic [SAMPLE_W-1:0]    r_mean;
    t_gain_item             r_item;
    logic                   m_ready, g_ready;
    logic [MEAN_PROD_W-1:0] mean_prod;
    logic [Q6_W-1:0]        mean_q6, diff;

    assign g_ready = !r_g_vld || i_ready;
    assign m_ready = !r_m_vld || g_ready;
    assign o_ready = m_ready;

    // Stage 1: sum / N, keep the low 10 bits
    assign mean_prod = MEAN_PROD_W'(i_sum) * MEAN_PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (m_ready) begin
            r_m_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && m_ready) begin
            r_mean <= mean_prod[RECIP_K +: SAMPLE_W];
        end
    end

    // Stage 2: (mean_q6 - offset) * gain
    assign mean_q6 = {r_mean, {FRAC_W{1'b0}}};
    assign diff    = mean_q6 - i_offset_q6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else if (g_ready) begin
            r_g_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_m_vld && g_ready) begin
            r_item.pos  <= (mean_q6 > i_offset_q6);
            r_item.prod <= PROD_W'(diff) * PROD_W'(i_gain_q12);
        end
    end

    assign o_valid = r_g_vld;
    assign o_item  = r_item;

endmodule

/* hw/rtl/pad_hold.sv */
// pad_hold: clamps the level, applies the deadband against the held level, result register.
// Depends on pad_pkg.
module pad_hold
    import pad_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  t_gain_item      i_item,
    output logic            o_ready,
    input  logic [Q6_W-1:0] i_deadband_q6,
    output logic            o_valid,
    output logic [Q6_W-1:0] o_level_q6,
    output logic            o_changed,
    input  logic            i_stall
);

    logic                r_vld, r_changed;
    logic [Q6_W-1:0]     r_held;
    logic [LEVEL_W-1:0]  raw;
    logic [Q6_W-1:0]     level, delta;
    logic                moved, take;

    assign o_ready = !r_vld || !i_stall;
    assign take    = i_valid && o_ready;

    // Clamp: tiny or negative to 0, above 1020.0 to 1023.0
    assign raw = i_item.prod[PROD_W-1:GAIN_SH];
    always_comb begin
        if (!i_item.pos || raw < LEVEL_FLOOR_Q6) begin
            level = '0;
        end else if (raw > LEVEL_TOP_Q6) begin
            level = LEVEL_MAX_Q6;
        end else begin
            level = raw[Q6_W-1:0];
        end
    end

    // Deadband: strictly greater distance replaces the held level
    assign delta = (level > r_held) ? (level - r_held) : (r_held - level);
    assign moved = delta > i_deadband_q6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_held    <= '0;
            r_changed <= 1'b0;
        end else if (take) begin
            r_vld     <= 1'b1;
            r_changed <= moved;
            if (moved) begin
                r_held <= level;
            end
        end else if (!i_stall) begin
            r_vld <= 1'b0;
        end
    end

    assign o_valid    = r_vld;
    assign o_level_q6 = r_held;
    assign o_changed  = r_changed;

endmodule

/* hw/rtl/pot_average_deadband.sv */
// pot_average_deadband: top level; config registers and the accumulate/condition/hold chain.
// Depends on pad_pkg, pad_accum, pad_cond, pad_hold.
//
//  channel | valid           | stall           | payload
//  --------+-----------------+-----------------+---------------------------
//  sample  | i_sample_valid  | o_sample_stall  | i_sample
//  result  | o_result_valid  | i_result_stall  | o_level_q6, o_changed
//  config  | i_cfg_we        | (none)          | i_cfg_index, i_cfg_data
//
// One sample is taken every cycle while o_sample_stall is low. The edge that takes
// the last sample of a group loads the group register; the mean, gain and result
// registers follow in that order, and o_result_valid rises as the result register loads.
// Each stage holds one group, so up to four results can be in flight while the
// output is stalled; the input stalls whenever the group register holds a
// finished group that cannot move on.
// Synchronous active-low reset clears the sum, count, held level, valids
// and restores the config registers.
module pot_average_deadband
    import pad_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_sample_valid,
    input  logic [SAMPLE_W-1:0]  i_sample,
    output logic                 o_sample_stall,
    output logic                 o_result_valid,
    output logic [Q6_W-1:0]      o_level_q6,
    output logic                 o_changed,
    input  logic                 i_result_stall,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [Q6_W-1:0]      i_cfg_data
);

    logic [Q6_W-1:0] r_offset_q6, r_gain_q12, r_deadband_q6;
    logic            grp_valid, grp_ready, g_valid, g_ready;
    logic [Q6_W-1:0] grp_sum;
    t_gain_item      g_item;

    // Config registers; unknown index is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_q6   <= OFFSET_RST;
            r_gain_q12    <= GAIN_RST;
            r_deadband_q6 <= DEADBAND_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_OFFSET:   r_offset_q6   <= i_cfg_data;
                CFG_GAIN:     r_gain_q12    <= i_cfg_data;
                CFG_DEADBAND: r_deadband_q6 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pad_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_sample_valid),
        .i_sample    (i_sample),
        .o_stall     (o_sample_stall),
        .o_grp_valid (grp_valid),
        .o_grp_sum   (grp_sum),
        .i_grp_ready (grp_ready)
    );

    pad_cond u_cond (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (grp_valid),
        .i_sum       (grp_sum),
        .o_ready     (grp_ready),
        .i_offset_q6 (r_offset_q6),
        .i_gain_q12  (r_gain_q12),
        .o_valid     (g_valid),
        .o_item      (g_item),
        .i_ready     (g_ready)
    );

    pad_hold u_hold (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (g_valid),
        .i_item        (g_item),
        .o_ready       (g_ready),
        .i_deadband_q6 (r_deadband_q6),
        .o_valid       (o_result_valid),
        .o_level_q6    (o_level_q6),
        .o_changed     (o_changed),
        .i_stall       (i_result_stall)
    );

endmodule
